// ===== hw/rtl/tt_pkg.sv =====
// ----------------------------------------------------------------------------
// Text terminal package
// Shared types, character codes and helpers for the text terminal cell engine.
// ----------------------------------------------------------------------------
package tt_pkg;

   typedef enum logic [1:0] {
      PH_NORMAL = 2'd0,
      PH_ESC    = 2'd1,
      PH_CSI    = 2'd2
   } tt_phase_type;

   typedef struct packed {
      logic write_cell;
      logic blank;
      logic clear_all;
      logic scroll_up;
   } tt_act_type;

   localparam logic [7:0] CH_BS       = 8'h08;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_ESC      = 8'd27;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_TWO      = 8'h32;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_H        = 8'h48;
   localparam logic [7:0] CH_J        = 8'h4A;
   localparam logic [7:0] CH_DEL      = 8'h7F;
   localparam logic [7:0] FINAL_LO    = 8'h40;
   localparam logic [7:0] FINAL_HI    = 8'h7E;
   localparam logic [7:0] NUM_SAT     = 8'hFF;

   function automatic logic [7:0] tt_accumulate(input logic [7:0] num, input logic [3:0] d);
      logic [11:0] v;
      v = {1'b0, num, 3'b000} + {3'b000, num, 1'b0} + {8'h00, d};
      return (v > {4'h0, NUM_SAT}) ? NUM_SAT : v[7:0];
   endfunction

endpackage

// ===== hw/rtl/tt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1200
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tt_parser.sv =====
// ----------------------------------------------------------------------------
// Text terminal parser
// Escape sequence parser and cursor tracker; emits the cell actions of a byte.
// ----------------------------------------------------------------------------
module tt_parser
   import tt_pkg::*;
#(
   parameter int ROW_COUNT = 20,
   parameter int COL_COUNT = 60,
   parameter int PARAM_MAX = 15
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [7:0]                   char_in,
   output logic [$clog2(ROW_COUNT)-1:0] cur_row,
   output logic [$clog2(COL_COUNT)-1:0] cur_col,
   output tt_phase_type                 phase,
   output tt_act_type                   act,
   output logic [$clog2(ROW_COUNT)-1:0] wr_row,
   output logic [$clog2(COL_COUNT)-1:0] wr_col
);

   localparam int RW = $clog2(ROW_COUNT);
   localparam int CW = $clog2(COL_COUNT);
   localparam logic [RW:0]   ROW_END  = (RW+1)'(ROW_COUNT);
   localparam logic [RW-1:0] ROW_LAST = RW'(ROW_COUNT - 1);
   localparam logic [CW-1:0] COL_LAST = CW'(COL_COUNT - 1);

   tt_phase_type  phase_ff, phase_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [3:0]    len_ff, len_in;
   logic [7:0]    first_ff, first_in;
   logic [7:0]    rnum_ff, rnum_in;
   logic [7:0]    cnum_ff, cnum_in;
   logic          semi_ff, semi_in;

   logic          plain;
   logic [RW:0]   row_next;
   logic [7:0]    home_row;
   logic [7:0]    home_col;
   logic [3:0]    digit_val;

   always_comb begin
      phase_in  = phase_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      len_in    = len_ff;
      first_in  = first_ff;
      rnum_in   = rnum_ff;
      cnum_in   = cnum_ff;
      semi_in   = semi_ff;
      act       = '0;
      wr_row    = row_ff;
      wr_col    = col_ff;
      plain     = 1'b0;
      row_next  = {1'b0, row_ff};
      home_row  = (rnum_ff != 8'd0) ? rnum_ff - 8'd1 : 8'd0;
      home_col  = (cnum_ff != 8'd0) ? cnum_ff - 8'd1 : 8'd0;
      digit_val = 4'(char_in - CH_ZERO);

      unique case (phase_ff)
         PH_ESC: begin
            if (char_in == CH_LBRACKET) begin
               phase_in = PH_CSI;
               len_in   = '0;
               first_in = '0;
               rnum_in  = '0;
               cnum_in  = '0;
               semi_in  = 1'b0;
            end else begin
               phase_in = PH_NORMAL;
               plain    = 1'b1;
            end
         end
         PH_CSI: begin
            if ((char_in >= CH_ZERO && char_in <= CH_NINE) || char_in == CH_SEMI) begin
               if (len_ff < 4'(PARAM_MAX)) begin
                  if (len_ff == 4'd0) begin
                     first_in = char_in;
                  end
                  len_in = len_ff + 4'd1;
                  if (semi_ff) begin
                     cnum_in = tt_accumulate(cnum_ff, digit_val);
                  end else if (char_in == CH_SEMI) begin
                     semi_in = 1'b1;
                  end else begin
                     rnum_in = tt_accumulate(rnum_ff, digit_val);
                  end
               end
            end else if (char_in >= FINAL_LO && char_in <= FINAL_HI) begin
               if (char_in == CH_J && (first_ff == CH_TWO || len_ff == 4'd0)) begin
                  act.clear_all = 1'b1;
               end
               if (char_in == CH_H) begin
                  if (home_row < 8'(ROW_COUNT)) begin
                     row_in = RW'(home_row);
                  end
                  if (home_col < 8'(COL_COUNT)) begin
                     col_in = CW'(home_col);
                  end
               end
               phase_in = PH_NORMAL;
            end
         end
         default: begin
            if (char_in == CH_ESC) begin
               phase_in = PH_ESC;
            end else begin
               plain = 1'b1;
            end
         end
      endcase

      if (plain) begin
         if (char_in == CH_LF) begin
            col_in   = '0;
            row_next = {1'b0, row_ff} + (RW+1)'(1);
         end else if (char_in == CH_BS || char_in == CH_DEL) begin
            if (col_ff != '0) begin
               col_in         = col_ff - CW'(1);
               wr_col         = col_ff - CW'(1);
               act.write_cell = 1'b1;
               act.blank      = 1'b1;
            end else if (row_ff != '0) begin
               row_next       = {1'b0, row_ff} - (RW+1)'(1);
               col_in         = COL_LAST;
               wr_row         = row_ff - RW'(1);
               wr_col         = COL_LAST;
               act.write_cell = 1'b1;
               act.blank      = 1'b1;
            end
         end else begin
            act.write_cell = 1'b1;
            if (col_ff == COL_LAST) begin
               col_in   = '0;
               row_next = {1'b0, row_ff} + (RW+1)'(1);
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
         if (row_next == ROW_END) begin
            act.scroll_up = 1'b1;
            row_in        = ROW_LAST;
         end else begin
            row_in = row_next[RW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL;
         row_ff   <= '0;
         col_ff   <= '0;
         len_ff   <= '0;
         first_ff <= '0;
         rnum_ff  <= '0;
         cnum_ff  <= '0;
         semi_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         len_ff   <= len_in;
         first_ff <= first_in;
         rnum_ff  <= rnum_in;
         cnum_ff  <= cnum_in;
         semi_ff  <= semi_in;
      end
   end

   assign cur_row = row_ff;
   assign cur_col = col_ff;
   assign phase   = phase_ff;

endmodule

// ===== hw/rtl/text_terminal_cell_engine_core.sv =====
// ----------------------------------------------------------------------------
// Text terminal cell engine
// Character terminal over a cell RAM with cursor, escape parsing and scrolling.
// ----------------------------------------------------------------------------
// A read passes S_READ, a write S_ACT, then S_DONE registers rsp_tvalid once the output is free.
// A screen clear or a scroll adds a pass over all ROW_COUNT*COL_COUNT cells, one RAM write per cycle.
// Only one transfer is in flight at a time; req_tready is high only in S_IDLE.
// After reset every cell of the RAM is filled with spaces, with req_tready low;
// cursor and parser state clear at once.
module text_terminal_cell_engine_core
   import tt_pkg::*;
#(
   parameter int ROW_COUNT = 20,
   parameter int COL_COUNT = 60,
   parameter int PARAM_MAX = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // char_in[7:0], read_row[12:8], read_col[18:13]
   input  logic [0:0]  req_tuser,  // cmd[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // cell_char[7:0], row[12:8], col[18:13], phase[20:19]
);

   localparam int CELL_COUNT = ROW_COUNT * COL_COUNT;
   localparam int AW = $clog2(CELL_COUNT);
   localparam int RW = $clog2(ROW_COUNT);
   localparam int CW = $clog2(COL_COUNT);
   localparam logic [AW-1:0] CELL_LAST = AW'(CELL_COUNT - 1);
   localparam logic [AW-1:0] TOP_SIZE  = AW'(CELL_COUNT - COL_COUNT);
   localparam logic [AW-1:0] ROW_STEP  = AW'(COL_COUNT);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_READ,
      S_ACT,
      S_CLEAR,
      S_SCROLL,
      S_DONE
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] sc_ff, sc_in;
   tt_act_type    act_ff, act_in;
   logic [AW-1:0] act_addr_ff, act_addr_in;
   logic [7:0]    act_data_ff, act_data_in;
   logic          in_range_ff, in_range_in;
   logic [7:0]    cell_ff, cell_in;
   logic          sh_vld_ff, sh_vld_in;
   logic [AW-1:0] sh_addr_ff, sh_addr_in;
   logic          sh_blank_ff, sh_blank_in;
   logic          rsp_vld_ff, rsp_vld_in;
   logic [23:0]   rsp_data_ff, rsp_data_in;

   logic          req_cmd;
   logic [7:0]    req_char;
   logic [4:0]    req_row;
   logic [5:0]    req_col;
   logic          accept;
   logic          par_step;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   logic [RW-1:0] par_row;
   logic [CW-1:0] par_col;
   tt_phase_type  par_phase;
   tt_act_type    par_act;
   logic [RW-1:0] par_wr_row;
   logic [CW-1:0] par_wr_col;

   assign req_cmd  = req_tuser[0];
   assign req_char = req_tdata[7:0];
   assign req_row  = req_tdata[12:8];
   assign req_col  = req_tdata[18:13];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign par_step   = accept && !req_cmd;

   tt_parser #(
      .ROW_COUNT (ROW_COUNT),
      .COL_COUNT (COL_COUNT),
      .PARAM_MAX (PARAM_MAX)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (par_step),
      .char_in (req_char),
      .cur_row (par_row),
      .cur_col (par_col),
      .phase   (par_phase),
      .act     (par_act),
      .wr_row  (par_wr_row),
      .wr_col  (par_wr_col)
   );

   tt_ram #(
      .WIDTH (8),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = sc_ff;
      ram_wr_data = CH_SPACE;
      if (sh_vld_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = sh_addr_ff;
         ram_wr_data = sh_blank_ff ? CH_SPACE : ram_rd_data;
      end else if (state_ff == S_INIT || state_ff == S_CLEAR) begin
         ram_wr_en = 1'b1;
      end else if (state_ff == S_ACT) begin
         ram_wr_en   = act_ff.write_cell;
         ram_wr_addr = act_addr_ff;
         ram_wr_data = act_data_ff;
      end
      if (state_ff == S_SCROLL) begin
         ram_rd_addr = sc_ff + ROW_STEP;
      end else begin
         ram_rd_addr = AW'(int'(req_row) * COL_COUNT + int'(req_col));
      end
   end

   always_comb begin
      state_in    = state_ff;
      sc_in       = sc_ff;
      act_in      = act_ff;
      act_addr_in = act_addr_ff;
      act_data_in = act_data_ff;
      in_range_in = in_range_ff;
      cell_in     = cell_ff;
      sh_vld_in   = 1'b0;
      sh_addr_in  = sc_ff;
      sh_blank_in = (sc_ff >= TOP_SIZE);
      rsp_data_in = rsp_data_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;

      unique case (state_ff)
         S_INIT: begin
            if (sc_ff == CELL_LAST) begin
               sc_in    = '0;
               state_in = S_IDLE;
            end else begin
               sc_in = sc_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_cmd) begin
                  in_range_in = (int'(req_row) < ROW_COUNT) && (int'(req_col) < COL_COUNT);
                  state_in    = S_READ;
               end else begin
                  act_in      = par_act;
                  act_addr_in = AW'(int'(par_wr_row) * COL_COUNT + int'(par_wr_col));
                  act_data_in = par_act.blank ? CH_SPACE : req_char;
                  cell_in     = 8'd0;
                  state_in    = S_ACT;
               end
            end
         end
         S_READ: begin
            cell_in  = in_range_ff ? ram_rd_data : 8'd0;
            state_in = S_DONE;
         end
         S_ACT: begin
            sc_in = '0;
            if (act_ff.clear_all) begin
               state_in = S_CLEAR;
            end else if (act_ff.scroll_up) begin
               state_in = S_SCROLL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CLEAR: begin
            if (sc_ff == CELL_LAST) begin
               state_in = S_DONE;
            end else begin
               sc_in = sc_ff + AW'(1);
            end
         end
         S_SCROLL: begin
            sh_vld_in = 1'b1;
            if (sc_ff == CELL_LAST) begin
               state_in = S_DONE;
            end else begin
               sc_in = sc_ff + AW'(1);
            end
         end
         S_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {3'b000, par_phase, 6'(par_col), 5'(par_row), cell_ff};
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_INIT;
         sc_ff      <= '0;
         sh_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sc_ff      <= sc_in;
         sh_vld_ff  <= sh_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      act_ff      <= act_in;
      act_addr_ff <= act_addr_in;
      act_data_ff <= act_data_in;
      in_range_ff <= in_range_in;
      cell_ff     <= cell_in;
      sh_addr_ff  <= sh_addr_in;
      sh_blank_ff <= sh_blank_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_scroll_write_no_accept: assert property (@(posedge clock) disable iff (reset)
      sh_vld_ff |-> !req_tready)
      else $error("scroll write pending while a transfer is taken");

   a_act_after_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACT) |-> $past(req_tvalid && req_tready && !req_tuser[0]))
      else $error("cell action without a write transfer");

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (int'(par_row) < ROW_COUNT) && (int'(par_col) < COL_COUNT))
      else $error("cursor outside the screen");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> ({1'b0, ram_wr_addr} < (AW+1)'(CELL_COUNT)))
      else $error("cell write beyond the store");

endmodule
